FILE: hw/rtl/lsbs_pkg.sv
`timescale 1ns / 1ps
package lsbs_pkg;

   localparam int LED_LANES   = 3;
   localparam int KIND_W      = 3;
   localparam int LEVEL_W     = 7;
   localparam int ATTR_W      = 8;
   localparam int VALUE_W     = 16;
   localparam int BRIGHT_W    = 8;
   localparam int MODE_W      = 2;
   localparam int PERIOD_W    = 5;
   localparam int STEP_W      = 9;
   localparam int FOLLOW_W    = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KIND_W-1:0] KIND_TICK      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SHOW_BATT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SHOW_CONN = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ATTR      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CHARGER   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_LEVEL     = 3'd5;

   localparam logic [ATTR_W-1:0] ATTR_CPI   = 8'd0;
   localparam logic [ATTR_W-1:0] ATTR_POWER = 8'd1;

   localparam logic [CSR_INDEX_W-1:0] CSR_BATTERY_HIGH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BATTERY_MID    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BATTERY_LOW    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CPI_ULTRA      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CPI_HIGH       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CPI_MID        = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS_MAX = 3'd6;

   localparam logic [MODE_W-1:0] MODE_IDLE       = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CHARGING   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DISCHARGED = 2'd2;

   localparam logic [FOLLOW_W-1:0] FOLLOW_NONE       = 2'd0;
   localparam logic [FOLLOW_W-1:0] FOLLOW_CHARGING   = 2'd1;
   localparam logic [FOLLOW_W-1:0] FOLLOW_DISCHARGED = 2'd2;

   localparam logic [LED_LANES-1:0] MASK_NONE  = 3'b000;
   localparam logic [LED_LANES-1:0] MASK_001   = 3'b001;
   localparam logic [LED_LANES-1:0] MASK_010   = 3'b010;
   localparam logic [LED_LANES-1:0] MASK_011   = 3'b011;
   localparam logic [LED_LANES-1:0] MASK_100   = 3'b100;
   localparam logic [LED_LANES-1:0] MASK_101   = 3'b101;
   localparam logic [LED_LANES-1:0] MASK_ALL   = 3'b111;

   localparam logic [PERIOD_W-1:0] CHG_PERIOD  = 5'd20;
   localparam logic [PERIOD_W-1:0] DIS_PERIOD  = 5'd5;
   localparam logic [PERIOD_W-1:0] SHOW_PERIOD = 5'd5;
   localparam logic [PERIOD_W-1:0] PWR_PERIOD  = 5'd3;

   localparam logic [LEVEL_W-1:0]  BATT_HIGH_RESET = 7'd80;
   localparam logic [LEVEL_W-1:0]  BATT_MID_RESET  = 7'd50;
   localparam logic [LEVEL_W-1:0]  BATT_LOW_RESET  = 7'd20;
   localparam logic [VALUE_W-1:0]  CPI_ULTRA_RESET = 16'd3200;
   localparam logic [VALUE_W-1:0]  CPI_HIGH_RESET  = 16'd1600;
   localparam logic [VALUE_W-1:0]  CPI_MID_RESET   = 16'd800;
   localparam logic [BRIGHT_W-1:0] BRIGHT_RESET    = 8'd100;

   // classified item passed from front to back
   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [LED_LANES-1:0] start_mask;
      logic [PERIOD_W-1:0]  start_period;
      logic                 queue_ramp;
      logic [LED_LANES-1:0] queue_mask;
      logic                 level_low;
      logic                 charging;
   } item_type;

endpackage

FILE: hw/rtl/led_status_breathing_sequencer.sv
`timescale 1ns / 1ps
// an item is held in a slot of the front-to-back queue and then in the back end's output
// register before its result is on rsp; a stall on rsp can keep it waiting in the queue
// throughput: one item per cycle while rsp_ready is high, set by the back end's state update
// a two-entry queue between front and back keeps req_ready high while rsp stalls briefly
// reset (synchronous, active high) clears mode, ramp and queue, and loads the
// default thresholds and peak brightness
module led_status_breathing_sequencer
   import lsbs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [LEVEL_W-1:0]     req_level,
   input  logic [ATTR_W-1:0]      req_attr,
   input  logic [VALUE_W-1:0]     req_value,
   input  logic                   req_charging,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [BRIGHT_W-1:0]    rsp_led_a,
   output logic [BRIGHT_W-1:0]    rsp_led_b,
   output logic [BRIGHT_W-1:0]    rsp_led_c,
   output logic                   rsp_ldo_enable,
   output logic [MODE_W-1:0]      rsp_mode,
   output logic                   rsp_busy_res
);

   logic                queue_full, queue_empty;
   logic                push, pop;
   item_type            push_item, pop_item;
   logic [BRIGHT_W-1:0] brightness_max;

   lsbs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_level      (req_level),
      .req_attr       (req_attr),
      .req_value      (req_value),
      .req_charging   (req_charging),
      .queue_full     (queue_full),
      .push           (push),
      .push_item      (push_item),
      .brightness_max (brightness_max)
   );

   lsbs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .pop_item  (pop_item)
   );

   lsbs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .pop            (pop),
      .pop_item       (pop_item),
      .brightness_max (brightness_max),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_led_a      (rsp_led_a),
      .rsp_led_b      (rsp_led_b),
      .rsp_led_c      (rsp_led_c),
      .rsp_ldo_enable (rsp_ldo_enable),
      .rsp_mode       (rsp_mode),
      .rsp_busy_res   (rsp_busy_res)
   );

endmodule

FILE: hw/rtl/lsbs_front.sv
`timescale 1ns / 1ps
module lsbs_front
   import lsbs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [LEVEL_W-1:0]     req_level,
   input  logic [ATTR_W-1:0]      req_attr,
   input  logic [VALUE_W-1:0]     req_value,
   input  logic                   req_charging,
   input  logic                   queue_full,
   output logic                   push,
   output item_type               push_item,
   output logic [BRIGHT_W-1:0]    brightness_max
);

   logic [LEVEL_W-1:0]  batt_high_ff, batt_mid_ff, batt_low_ff;
   logic [VALUE_W-1:0]  cpi_ultra_ff, cpi_high_ff, cpi_mid_ff;
   logic [BRIGHT_W-1:0] bright_max_ff;

   assign csr_ready      = 1'b1;
   assign brightness_max = bright_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         batt_high_ff  <= BATT_HIGH_RESET;
         batt_mid_ff   <= BATT_MID_RESET;
         batt_low_ff   <= BATT_LOW_RESET;
         cpi_ultra_ff  <= CPI_ULTRA_RESET;
         cpi_high_ff   <= CPI_HIGH_RESET;
         cpi_mid_ff    <= CPI_MID_RESET;
         bright_max_ff <= BRIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BATTERY_HIGH:   batt_high_ff  <= csr_data[LEVEL_W-1:0];
            CSR_BATTERY_MID:    batt_mid_ff   <= csr_data[LEVEL_W-1:0];
            CSR_BATTERY_LOW:    batt_low_ff   <= csr_data[LEVEL_W-1:0];
            CSR_CPI_ULTRA:      cpi_ultra_ff  <= csr_data;
            CSR_CPI_HIGH:       cpi_high_ff   <= csr_data;
            CSR_CPI_MID:        cpi_mid_ff    <= csr_data;
            CSR_BRIGHTNESS_MAX: bright_max_ff <= csr_data[BRIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_item              = '0;
      push_item.kind         = req_kind;
      push_item.charging     = req_charging;
      push_item.level_low    = (req_level <= batt_low_ff);
      push_item.start_period = SHOW_PERIOD;
      unique case (req_kind)
         KIND_SHOW_BATT, KIND_SHOW_CONN: begin
            priority if (req_level > batt_high_ff) push_item.start_mask = MASK_010;
            else if (req_level > batt_mid_ff)      push_item.start_mask = MASK_011;
            else if (req_level > batt_low_ff)      push_item.start_mask = MASK_001;
            else                                   push_item.start_mask = MASK_NONE;
         end
         KIND_ATTR: begin
            if (req_attr == ATTR_CPI) begin
               priority if (req_value > cpi_ultra_ff) push_item.start_mask = MASK_101;
               else if (req_value > cpi_high_ff)      push_item.start_mask = MASK_010;
               else if (req_value > cpi_mid_ff)       push_item.start_mask = MASK_011;
               else                                   push_item.start_mask = MASK_001;
            end else if (req_attr == ATTR_POWER) begin
               // all-led prefix, then the power mode band
               push_item.start_mask   = MASK_ALL;
               push_item.start_period = PWR_PERIOD;
               push_item.queue_ramp   = 1'b1;
               priority if (req_value == 16'd0) push_item.queue_mask = MASK_101;
               else if (req_value == 16'd1)     push_item.queue_mask = MASK_011;
               else if (req_value == 16'd2)     push_item.queue_mask = MASK_100;
               else                             push_item.queue_mask = MASK_001;
            end
         end
         default: ;
      endcase
   end

endmodule

FILE: hw/rtl/lsbs_queue.sv
`timescale 1ns / 1ps
module lsbs_queue
   import lsbs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type pop_item
);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hw/rtl/lsbs_back.sv
`timescale 1ns / 1ps
module lsbs_back
   import lsbs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   output logic                pop,
   input  item_type            pop_item,
   input  logic [BRIGHT_W-1:0] brightness_max,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BRIGHT_W-1:0] rsp_led_a,
   output logic [BRIGHT_W-1:0] rsp_led_b,
   output logic [BRIGHT_W-1:0] rsp_led_c,
   output logic                rsp_ldo_enable,
   output logic [MODE_W-1:0]   rsp_mode,
   output logic                rsp_busy_res
);

   typedef struct packed {
      logic [MODE_W-1:0]    cur_mode;
      logic [LED_LANES-1:0] ramp_mask;
      logic [PERIOD_W-1:0]  ramp_period;
      logic [STEP_W-1:0]    ramp_step;
      logic [PERIOD_W-1:0]  tick_count;
      logic [LED_LANES-1:0] queued_mask;
      logic                 queued_valid;
      logic [FOLLOW_W-1:0]  follow_up;
      logic                 active;
   } state_type;

   function automatic state_type start_ramp(state_type s, logic [LED_LANES-1:0] m,
                                            logic [PERIOD_W-1:0] p);
      state_type r;
      r             = s;
      r.ramp_mask   = m;
      r.ramp_period = p;
      r.ramp_step   = '0;
      r.tick_count  = '0;
      r.active      = 1'b1;
      return r;
   endfunction

   function automatic state_type begin_follow(state_type s);
      state_type r;
      r = s;
      priority if (s.queued_valid) begin
         r.queued_valid = 1'b0;
         r = start_ramp(r, s.queued_mask, PWR_PERIOD);
      end else if (s.follow_up == FOLLOW_CHARGING) begin
         r.cur_mode = MODE_CHARGING;
         r = start_ramp(r, MASK_011, CHG_PERIOD);
      end else if (s.follow_up == FOLLOW_DISCHARGED) begin
         r.cur_mode = MODE_DISCHARGED;
         r = start_ramp(r, MASK_001, DIS_PERIOD);
      end else begin
         r.active     = 1'b0;
         r.ramp_mask  = MASK_NONE;
         r.ramp_step  = '0;
         r.tick_count = '0;
      end
      return r;
   endfunction

   function automatic state_type cancel(state_type s);
      state_type r;
      r              = s;
      r.queued_valid = 1'b0;
      r.active       = 1'b0;
      r.ramp_mask    = MASK_NONE;
      return r;
   endfunction

   function automatic logic [FOLLOW_W-1:0] follow_from_mode(logic [MODE_W-1:0] m);
      logic [FOLLOW_W-1:0] f;
      f = FOLLOW_NONE;
      if (m == MODE_CHARGING) f = FOLLOW_CHARGING;
      else if (m == MODE_DISCHARGED) f = FOLLOW_DISCHARGED;
      return f;
   endfunction

   state_type             st_ff, st_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BRIGHT_W-1:0]   led_ff [LED_LANES];
   logic [BRIGHT_W-1:0]   led_in [LED_LANES];
   logic [MODE_W-1:0]     mode_ff;
   logic                  active_ff;

   logic [PERIOD_W-1:0]   per;
   logic [PERIOD_W:0]     tick_inc;
   logic [STEP_W-1:0]     last;
   logic [STEP_W-1:0]     bright;
   logic                  mode_free;

   assign pop       = !queue_empty && (!rsp_valid_ff || rsp_ready);
   assign last      = {brightness_max, 1'b0};
   assign per       = (st_ff.ramp_period == '0) ? PERIOD_W'(1) : st_ff.ramp_period;
   assign tick_inc  = {1'b0, st_ff.tick_count} + 1'b1;
   assign mode_free = (st_ff.cur_mode != MODE_CHARGING) && (st_ff.cur_mode != MODE_DISCHARGED);

   always_comb begin
      st_in = st_ff;
      unique case (pop_item.kind)
         KIND_TICK: begin
            if (st_ff.active) begin
               if (tick_inc >= {1'b0, per}) begin
                  st_in.tick_count = '0;
                  if (st_ff.ramp_step >= last) st_in = begin_follow(st_in);
                  else st_in.ramp_step = st_ff.ramp_step + 1'b1;
               end else begin
                  st_in.tick_count = tick_inc[PERIOD_W-1:0];
               end
            end
         end
         KIND_SHOW_BATT, KIND_SHOW_CONN, KIND_ATTR: begin
            st_in           = cancel(st_in);
            st_in.follow_up = follow_from_mode(st_ff.cur_mode);
            // low-level rule applies to battery and connection shows, not to attribute shows
            if (pop_item.kind != KIND_ATTR && mode_free && pop_item.level_low) begin
               st_in.follow_up = FOLLOW_DISCHARGED;
            end
            if (pop_item.start_mask != MASK_NONE) begin
               st_in = start_ramp(st_in, pop_item.start_mask, pop_item.start_period);
               if (pop_item.queue_ramp) begin
                  st_in.queued_mask  = pop_item.queue_mask;
                  st_in.queued_valid = 1'b1;
               end
            end else begin
               st_in = begin_follow(st_in);
            end
         end
         KIND_CHARGER: begin
            st_in = cancel(st_in);
            if (pop_item.charging) begin
               st_in.cur_mode  = MODE_CHARGING;
               st_in.follow_up = FOLLOW_CHARGING;
               st_in = start_ramp(st_in, MASK_011, CHG_PERIOD);
            end else begin
               st_in.cur_mode   = MODE_IDLE;
               st_in.follow_up  = FOLLOW_NONE;
               st_in.ramp_step  = '0;
               st_in.tick_count = '0;
            end
         end
         KIND_LEVEL: begin
            if (mode_free && pop_item.level_low) begin
               st_in           = cancel(st_in);
               st_in.cur_mode  = MODE_DISCHARGED;
               st_in.follow_up = FOLLOW_DISCHARGED;
               st_in = start_ramp(st_in, MASK_001, DIS_PERIOD);
            end
         end
         default: ;
      endcase
   end

   // brightness from the updated ramp position
   always_comb begin
      bright = '0;
      if (st_in.active && st_in.ramp_step <= last) begin
         bright = (st_in.ramp_step <= {1'b0, brightness_max}) ? st_in.ramp_step
                                                               : last - st_in.ramp_step;
      end
      for (int i = 0; i < LED_LANES; i++) begin
         led_in[i] = (st_in.active && st_in.ramp_mask[i]) ? bright[BRIGHT_W-1:0] : '0;
      end
   end

   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            st_ff <= st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         for (int i = 0; i < LED_LANES; i++) begin
            led_ff[i] <= led_in[i];
         end
         mode_ff   <= st_in.cur_mode;
         active_ff <= st_in.active;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_led_a      = led_ff[0];
   assign rsp_led_b      = led_ff[1];
   assign rsp_led_c      = led_ff[2];
   assign rsp_ldo_enable = active_ff;
   assign rsp_busy_res   = active_ff;
   assign rsp_mode       = mode_ff;

endmodule

FILE: hw/rtl/lsbs_checker.sv
`timescale 1ns / 1ps
module lsbs_checker
   import lsbs_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [BRIGHT_W-1:0] rsp_led_a,
   input logic [BRIGHT_W-1:0] rsp_led_b,
   input logic [BRIGHT_W-1:0] rsp_led_c,
   input logic                rsp_ldo_enable,
   input logic [MODE_W-1:0]   rsp_mode,
   input logic                rsp_busy_res
);

   // no result is valid right after reset
   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_supply_follows_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ldo_enable == rsp_busy_res))
      else $error("ldo enable differs from busy");

   a_dark_when_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_busy_res) |->
         (rsp_led_a == '0 && rsp_led_b == '0 && rsp_led_c == '0))
      else $error("led lit while no ramp runs");

   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mode == MODE_IDLE || rsp_mode == MODE_CHARGING ||
                     rsp_mode == MODE_DISCHARGED))
      else $error("mode code out of range");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_led_a) && $stable(rsp_mode)))
      else $error("stalled result changed");

endmodule

bind led_status_breathing_sequencer lsbs_checker u_lsbs_checker (.*);
